/* hw/rtl/sis_pkg.sv */
package sis_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_CMP,
        S_WRITE,
        S_TOP,
        S_TOPWAIT
    } t_sis_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch the incoming word
        logic dec_pos;
        logic inc_count;
        logic dec_count;
        logic set_drop;
        logic mem_we;
        logic wsel_shift; // write data: 1 = shifted entry, 0 = new value
        logic rsel_top;   // read addr: 1 = count-1, 0 = pos-1
        logic emit;
    } t_sis_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic pos_one;
        logic key_less;   // entry at pos-1 is below the new value
    } t_sis_sts;

endpackage

/* hw/rtl/sis_ram.sv */
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sis_ctrl.sv */
module sis_ctrl
    import sis_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_sis_sts i_sts,
    output t_sis_cmd o_cmd
);

    t_sis_state r_state;
    t_sis_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.op_pop) begin
                    o_cmd.dec_count = !i_sts.empty;
                    n_state         = S_TOP;
                end else if (i_sts.full) begin
                    o_cmd.set_drop = 1'b1;
                    n_state        = S_TOP;
                end else if (i_sts.pos_zero) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // smaller entry moves up one slot; insertion point moves down
                if (i_sts.key_less) begin
                    o_cmd.mem_we     = 1'b1;
                    o_cmd.wsel_shift = 1'b1;
                    o_cmd.dec_pos    = 1'b1;
                    n_state          = i_sts.pos_one ? S_WRITE : S_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.inc_count = 1'b1;
                n_state         = S_TOP;
            end
            S_TOP: begin
                o_cmd.rsel_top = 1'b1;
                n_state        = S_TOPWAIT;
            end
            S_TOPWAIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* hw/rtl/sis_dpath.sv */
module sis_dpath
    import sis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_func,
    input  logic [DATA_W-1:0]  i_value,
    input  t_sis_cmd           i_cmd,
    output t_sis_sts           o_sts,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_top_value,
    output logic               o_is_empty,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_push_dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              r_func;
    logic [DATA_W-1:0] r_value;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_count;
    logic              r_drop;

    logic               r_valid;
    logic [DATA_W-1:0]  r_top;
    logic               r_empty;
    logic [COUNT_W-1:0] r_cnt_out;
    logic               r_dropped;

    logic [CW-1:0]         pos_m1;
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         raddr;
    logic [DATA_W-1:0]     wdata;
    logic [DATA_W-1:0]     rdata;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign pos_m1  = r_pos - CW'(1);
    assign cnt_m1  = r_count - CW'(1);
    assign raddr   = i_cmd.rsel_top ? cnt_m1[AW-1:0] : pos_m1[AW-1:0];
    assign wdata   = i_cmd.wsel_shift ? rdata : r_value;
    assign cnt_ext = {{COUNT_W{1'b0}}, r_count};

    sis_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_drop <= 1'b0;
            end else if (i_cmd.set_drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.inc_count) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_pos   <= r_count;
        end else if (i_cmd.dec_pos) begin
            r_pos <= pos_m1;
        end
        if (i_cmd.emit) begin
            r_top     <= (r_count == '0) ? '0 : rdata;
            r_empty   <= (r_count == '0);
            r_cnt_out <= cnt_ext[COUNT_W-1:0];
            r_dropped <= r_drop;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.op_pop   = r_func;
        o_sts.full     = (r_count == CW'(DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.pos_zero = (r_pos == '0);
        o_sts.pos_one  = (r_pos == CW'(1));
        o_sts.key_less = ($signed(rdata) < $signed(r_value));
    end

    assign o_valid        = r_valid;
    assign o_top_value    = r_top;
    assign o_is_empty     = r_empty;
    assign o_count        = r_cnt_out;
    assign o_push_dropped = r_dropped;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_we |-> (r_pos < r_count + CW'(1)) && (r_count != CW'(DEPTH)))
        else $error("write outside sorted region");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_dropped) |-> (r_count == CW'(DEPTH)))
        else $error("push dropped while not full");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

/* hw/rtl/sorted_insert_stack.sv */
// Channel  | Handshake               | Word
// ---------+-------------------------+------------------------------------------
// command  | start & !busy           | i_func, i_value
// result   | o_valid (one cycle)     | o_top_value, o_is_empty, o_count,
//          |                         | o_push_dropped
//
// Pop, or push into a full store: after the accept edge the controller steps
// through S_DECIDE, S_TOP and S_TOPWAIT; o_valid is registered from S_TOPWAIT.
// Push: S_DECIDE, then an S_RD/S_CMP pair (entry RAM read, compare-shift) per
// stored entry below the new value and one for the first entry not below it, if
// any; then S_WRITE, S_TOP, S_TOPWAIT. busy drops as the strobe rises; the next word is taken at the following edge.
// i_rst_n is synchronous, active low; it empties the store (RAM not cleared).
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_insert_stack
    import sis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [DATA_W-1:0]  i_value,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_top_value,
    output logic               o_is_empty,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_push_dropped
);

    t_sis_cmd cmd;
    t_sis_sts sts;

    sis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sis_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_top_value    (o_top_value),
        .o_is_empty     (o_is_empty),
        .o_count        (o_count),
        .o_push_dropped (o_push_dropped)
    );

endmodule

/* bench/sis_test_pkg.sv */
`timescale 1ns / 1ps
package sis_test_pkg;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

endpackage

/* bench/sorted_insert_stack_checker.sv */
`timescale 1ns / 1ps
module sorted_insert_stack_checker
    import sis_pkg::*;
    import sis_test_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_func,
    input  logic [DATA_W-1:0]  i_value,
    input  logic               o_valid,
    input  logic [DATA_W-1:0]  o_top_value,
    input  logic               o_is_empty,
    input  logic [COUNT_W-1:0] o_count,
    input  logic               o_push_dropped,
    output int                 pending,
    output int                 fail_count
);

    typedef struct packed {
        logic [DATA_W-1:0]  top_value;
        logic               is_empty;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_store_status;

    // descending order, smallest value at slot stored-1
    logic signed [DATA_W-1:0] store_mem [DEPTH];
    int                       stored;
    t_store_status            status_q [$];

    function automatic t_store_status apply_command(input logic op,
                                                    input logic signed [DATA_W-1:0] value);
        t_store_status st;
        int            pos;
        st.dropped = 1'b0;
        if (op == OP_PUSH) begin
            if (stored >= DEPTH) begin
                st.dropped = 1'b1;
            end else begin
                pos = stored;
                while (pos > 0 && store_mem[pos-1] < value) begin
                    store_mem[pos] = store_mem[pos-1];
                    pos--;
                end
                store_mem[pos] = value;
                stored++;
            end
        end else if (stored > 0) begin
            stored--;
        end
        st.top_value = (stored > 0) ? store_mem[stored-1] : '0;
        st.is_empty  = (stored == 0);
        st.count     = stored[COUNT_W-1:0];
        return st;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    initial begin
        stored     = 0;
        pending    = 0;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_store_status exp_st;
        t_store_status new_st;
        if (!i_rst_n) begin
            stored = 0;
            status_q.delete();
        end else begin
            // a result and the next word can meet on one edge: retire first
            if (o_valid) begin
                if (status_q.size() == 0) begin
                    $error("result word with no command outstanding");
                    fail_count++;
                end else begin
                    exp_st = status_q.pop_front();
                    check_field("top_value", exp_st.top_value, o_top_value);
                    check_field("is_empty", DATA_W'(exp_st.is_empty), DATA_W'(o_is_empty));
                    check_field("count", DATA_W'(exp_st.count), DATA_W'(o_count));
                    check_field("push_dropped", DATA_W'(exp_st.dropped),
                                DATA_W'(o_push_dropped));
                end
            end
            if (start && !busy) begin
                new_st   = apply_command(i_func, i_value);
                status_q = {status_q, new_st};
            end
        end
        pending = status_q.size();
    end

endmodule

/* bench/sorted_insert_stack_test.sv */
`timescale 1ns / 1ps
module sorted_insert_stack_test;
    import sis_pkg::*;
    import sis_test_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int WORDS_PER_PHASE = 580;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [DATA_W-1:0]  i_value;
    logic               o_valid;
    logic [DATA_W-1:0]  o_top_value;
    logic               o_is_empty;
    logic [COUNT_W-1:0] o_count;
    logic               o_push_dropped;
    int                 pending;
    int                 fail_count;
    int                 idle_pct;
    int                 stall_cycles;

    sorted_insert_stack #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_top_value    (o_top_value),
        .o_is_empty     (o_is_empty),
        .o_count        (o_count),
        .o_push_dropped (o_push_dropped)
    );

    sorted_insert_stack_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_top_value    (o_top_value),
        .o_is_empty     (o_is_empty),
        .o_count        (o_count),
        .o_push_dropped (o_push_dropped),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: cycles without any word moving on either channel
    initial stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_cmd(input t_op op, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= op;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // small values give runs of duplicates, extremes hit the sign boundary
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFE;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int idle_phases [3];
        int push_pct;
        idle_phases = '{0, 82, 23};
        start    = 1'b0;
        i_func   = OP_PUSH;
        i_value  = '0;
        i_rst_n  = 1'b0;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pop on empty, fill to full with extremes and duplicates, overflow, unwind
        send_cmd(OP_POP, 32'hDEAD_BEEF);
        send_cmd(OP_PUSH, 32'h0000_0000);
        send_cmd(OP_PUSH, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_PUSH, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH, 32'h0000_0001);
        send_cmd(OP_PUSH, 32'h0000_0000);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_PUSH, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH, 32'h0000_0005);
        send_cmd(OP_PUSH, 32'hFFFF_FFFB);
        send_cmd(OP_PUSH, 32'h0000_0000);
        send_cmd(OP_PUSH, 32'h0000_0064);
        send_cmd(OP_PUSH, 32'hFFFF_FF9C);
        send_cmd(OP_PUSH, 32'h8000_0001);
        send_cmd(OP_PUSH, 32'h7FFF_FFFE);
        send_cmd(OP_PUSH, 32'h0000_0000);
        send_cmd(OP_PUSH, 32'h0000_0007);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_POP, 32'hFFFF_FFFF);
        send_cmd(OP_POP, 32'h0000_0000);
        send_cmd(OP_POP, 32'h5555_5555);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_POP, 32'hAAAA_AAAA);
        drain_results();

        foreach (idle_phases[p]) begin
            idle_pct = idle_phases[p];
            push_pct = 50;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // shift the push/pop mix now and then so the fill level roams
                if (n % 40 == 0) begin
                    case ($urandom_range(3))
                        0: push_pct = 20;
                        1: push_pct = 50;
                        2: push_pct = 80;
                        default: push_pct = 95;
                    endcase
                end
                if ($urandom_range(99) < push_pct)
                    send_cmd(OP_PUSH, pick_value());
                else
                    send_cmd(OP_POP, $urandom());
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
